// ----- rtl/fld3_pkg.sv -----
// ----------------------------------------------------------------------------
// fld3_pkg: shared constants, types and tap table for the low-pass decimator
// Windowed-sinc base taps in Q1.15 and the scaling to other coefficient widths.
// ----------------------------------------------------------------------------
package fld3_pkg;

	localparam int unsigned SAMPLE_W   = 16;
	localparam int unsigned TAPS_DEF   = 31;
	localparam int unsigned DECIM_DEF  = 3;
	localparam int unsigned COEF_DEF   = 16;
	localparam int unsigned COEF_MAX_W = 24;
	localparam int unsigned BASE_TAPS  = 31;

	// 31-tap Hamming sinc, 7 kHz at 48 kHz, unit DC gain, Q1.15
	localparam logic signed [15:0] BASE_Q15 [BASE_TAPS] = '{
		16'sd51, 16'sd17, -16'sd58, -16'sd146, -16'sd134, 16'sd84, 16'sd426,
		16'sd555, 16'sd114, -16'sd838, -16'sd1591, -16'sd1105, 16'sd1213,
		16'sd4834, 16'sd8186, 16'sd9551, 16'sd8186, 16'sd4834, 16'sd1213,
		-16'sd1105, -16'sd1591, -16'sd838, 16'sd114, 16'sd555, 16'sd426,
		16'sd84, -16'sd134, -16'sd146, -16'sd58, 16'sd17, 16'sd51
	};

	// MAC unit control
	typedef struct packed {
		logic clr;      // zero product and accumulator
		logic prod_en;  // multiply this cycle
		logic acc_en;   // add product register into accumulator
	} mac_ctl_t;

	// Tap idx scaled to Q1.(coef_bits-1); narrower widths round half away
	// from zero, taps past the base table are zero.
	function automatic logic signed [COEF_MAX_W-1:0] tap_value(
		input int unsigned idx,
		input int unsigned coef_bits
	);
		logic signed [COEF_MAX_W-1:0] v;
		logic [COEF_MAX_W-1:0]        mag;
		logic [COEF_MAX_W-1:0]        q;
		int unsigned                  sh;
		v = '0;
		if (idx < BASE_TAPS) begin
			v = COEF_MAX_W'(BASE_Q15[idx]);
		end
		if (coef_bits >= 16) begin
			return v <<< (coef_bits - 16);
		end
		sh  = 16 - coef_bits;
		mag = v[COEF_MAX_W-1] ? COEF_MAX_W'(-v) : COEF_MAX_W'(v);
		q   = (mag + (COEF_MAX_W'(1) << (sh - 1))) >> sh;
		return v[COEF_MAX_W-1] ? COEF_MAX_W'(-q) : COEF_MAX_W'(q);
	endfunction

endpackage

// ----- rtl/fld3_mac.sv -----
// ----------------------------------------------------------------------------
// fld3_mac: shared multiply-accumulate unit
// Registered product, then wide accumulate; one tap per cycle.
// ----------------------------------------------------------------------------
module fld3_mac #(
	parameter int unsigned COEF_BITS = fld3_pkg::COEF_DEF,
	parameter int unsigned ACC_W     = 48
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  fld3_pkg::mac_ctl_t               ctl,
	input  logic signed [fld3_pkg::SAMPLE_W-1:0] operand,
	input  logic signed [COEF_BITS-1:0]      coef,
	output logic signed [ACC_W-1:0]          acc
);

	localparam int unsigned PROD_W = fld3_pkg::SAMPLE_W + COEF_BITS;

	logic signed [PROD_W-1:0] prod_s1;
	logic signed [ACC_W-1:0]  acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_s1 <= '0;
			acc_q   <= '0;
		end else if (ctl.clr) begin
			prod_s1 <= '0;
			acc_q   <= '0;
		end else begin
			prod_s1 <= ctl.prod_en ? PROD_W'(operand) * PROD_W'(coef) : '0;
			if (ctl.acc_en) begin
				acc_q <= acc_q + ACC_W'(prod_s1);
			end
		end
	end

	assign acc = acc_q;

endmodule

// ----- rtl/fir_lowpass_decimator_by_3_top.sv -----
// ----------------------------------------------------------------------------
// fir_lowpass_decimator_by_3_top: windowed-sinc low-pass FIR, decimate by 3
// One shared MAC walks the taps of each output; history rotates past it.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake                     Payload
// -------  ---  ----------------------------  ---------------------------------
// s_axis   in   s_axis_tvalid / s_axis_tready s_axis_tdata[15:0] = sample
// m_axis   out  m_axis_tvalid / m_axis_tready m_axis_tdata[15:0] = filtered_sample
//
// A sample that yields no output leaves the sequencer in idle, so those stream
// back to back. A sample that yields an output holds tready low after its
// transfer for the TAPS MAC steps, one accumulate drain and one round/saturate;
// the single shared multiplier sets this.
// Reset clears the history to zero and the decimation phase to zero.
// The output register decouples the sides: a new sample is taken while a
// result waits; only the round step waits if the output register is full.
//
module fir_lowpass_decimator_by_3_top #(
	parameter int unsigned TAPS       = fld3_pkg::TAPS_DEF,
	parameter int unsigned DECIMATION = fld3_pkg::DECIM_DEF,
	parameter int unsigned COEF_BITS  = fld3_pkg::COEF_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] sample
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata    // [15:0] filtered_sample
);

	localparam int unsigned SW     = fld3_pkg::SAMPLE_W;
	localparam int unsigned HIST_N = TAPS - 1;
	localparam int unsigned STEP_W = $clog2(TAPS);
	localparam int unsigned PH_W   = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
	localparam int unsigned FRAC   = COEF_BITS - 1;
	localparam int unsigned ACC_W  = SW + COEF_BITS + $clog2(TAPS) + 1;

	// one-hot sequencer
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_MAC   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_ROUND = 4'b1000
	} state_t;

	state_t                  state_q;
	logic [STEP_W-1:0]       step_q;
	logic [PH_W-1:0]         phase_q;
	logic signed [SW-1:0]    x_q;
	logic signed [SW-1:0]    hist_q [HIST_N];
	logic                    out_valid_q;
	logic [SW-1:0]           out_data_q;

	logic                    in_xfer;
	logic                    emit;
	logic                    last_step;
	logic                    out_load;
	fld3_pkg::mac_ctl_t      mac_ctl;
	logic signed [SW-1:0]    mac_op;
	logic signed [fld3_pkg::COEF_MAX_W-1:0] tap_full;
	logic signed [COEF_BITS-1:0] mac_coef;
	logic signed [ACC_W-1:0] acc;
	logic [ACC_W-1:0]        acc_mag;
	logic [ACC_W-1:0]        acc_rnd;
	logic [SW-1:0]           y_sat;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign emit          = (phase_q == '0);
	assign last_step     = (step_q == STEP_W'(TAPS - 1));
	assign out_load      = (state_q == ST_ROUND) && (!out_valid_q || m_axis_tready);

	// step 0 multiplies the new sample by the last tap; later steps take
	// the newest-first history as it rotates through position 0
	assign mac_op   = (step_q == '0) ? x_q : hist_q[0];
	assign tap_full = fld3_pkg::tap_value(TAPS - 1 - 32'(step_q), COEF_BITS);
	assign mac_coef = tap_full[COEF_BITS-1:0];

	always_comb begin
		mac_ctl.clr     = in_xfer;
		mac_ctl.prod_en = (state_q == ST_MAC);
		mac_ctl.acc_en  = (state_q == ST_MAC) || (state_q == ST_DRAIN);
	end

	fld3_mac #(
		.COEF_BITS (COEF_BITS),
		.ACC_W     (ACC_W)
	) u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mac_ctl),
		.operand (mac_op),
		.coef    (mac_coef),
		.acc     (acc)
	);

	// round half away from zero on the magnitude, then saturate to 16 bits
	always_comb begin
		acc_mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
		acc_rnd = (acc_mag + (ACC_W'(1) << (FRAC - 1))) >> FRAC;
		if (acc[ACC_W-1]) begin
			y_sat = (acc_rnd > ACC_W'(32768)) ? 16'h8000 : SW'(-acc_rnd);
		end else begin
			y_sat = (acc_rnd > ACC_W'(32767)) ? 16'h7fff : acc_rnd[SW-1:0];
		end
	end

	// sequencer, step and phase counters; the sample latch follows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			phase_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						phase_q <= (phase_q == PH_W'(DECIMATION - 1)) ? '0 : phase_q + 1'b1;
						step_q  <= '0;
						if (emit) begin
							state_q <= ST_MAC;
						end
					end
				end
				ST_MAC: begin
					step_q <= step_q + 1'b1;
					if (last_step) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			x_q <= s_axis_tdata;
		end
	end

	// history: rotate once per MAC step after the first, so TAPS-1 rotations
	// restore the order; the new sample is then shifted in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < HIST_N; j++) begin
				hist_q[j] <= '0;
			end
		end else if ((in_xfer && !emit) || state_q == ST_DRAIN) begin
			hist_q[0] <= (state_q == ST_DRAIN) ? x_q : s_axis_tdata;
			for (int j = 1; j < HIST_N; j++) begin
				hist_q[j] <= hist_q[j-1];
			end
		end else if (state_q == ST_MAC && step_q != '0) begin
			for (int j = 0; j < HIST_N - 1; j++) begin
				hist_q[j] <= hist_q[j+1];
			end
			hist_q[HIST_N-1] <= hist_q[0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= y_sat;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// ----- rtl/fld3_chk.sv -----
// ----------------------------------------------------------------------------
// fld3_chk: port-level checks for the low-pass decimator
// Watches the stream ports only; bound to the top level below.
// ----------------------------------------------------------------------------
module fld3_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output tvalid dropped while stalled");

	// a stalled result keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("output tdata changed while stalled");

	// the input side only closes right after a sample transfer
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_axis_tready) |-> $past(s_axis_tvalid && s_axis_tready))
		else $error("tready fell without a sample transfer");

	// a new result never appears the cycle after a sample transfer
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
		else $error("result appeared without MAC time");

	// a result can only be produced while the input side is busy
	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tready))
		else $error("result appeared while input side idle");

endmodule

bind fir_lowpass_decimator_by_3_top fld3_chk u_fld3_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
